/* rtl/lru_key_value_cache_top_defines.svh */
// Assertion macros shared by the cache checker.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    localparam int LKVC_CAPACITY = 16;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkvc_ent_t;

    typedef struct packed {
        logic cmp_en;   // register key compare this cycle
        logic load;     // take entry from neighbor
    } lkvc_ctrl_t;

endpackage

/* rtl/lkvc_cell.sv */
// One slot of the recency chain: entry storage plus key comparator.
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  lkvc_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] cmp_key,
    input  lkvc_ent_t        prev_ent,
    output lkvc_ent_t        ent,
    output logic             match
);

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic             match_reg, match_next;

    always_comb begin
        valid_next = ctrl.load ? prev_ent.valid : valid_reg;
        key_next   = ctrl.load ? prev_ent.key   : key_reg;
        value_next = ctrl.load ? prev_ent.value : value_reg;
        match_next = ctrl.cmp_en ? (valid_reg && (key_reg == cmp_key)) : match_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // payload needs no reset: invalid slots never match
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign ent   = '{valid: valid_reg, key: key_reg, value: value_reg};
    assign match = match_reg;

endmodule

/* rtl/lru_key_value_cache_top.sv */
// Top level of the fully associative LRU key-value cache.
//
// Request channel (s_): s_tuser[0] selects get (0) or put (1); s_tdata carries
// the key in bits 31:0 and the put value in bits 63:32. A request is taken
// when s_tvalid and s_tready are both high.
// Result channel (m_): one result per request. m_tuser holds hit and evicted
// flags, m_tdata the read value and the evicted key.
// Configuration: cfg_we writes cfg_wdata into capacity_in_use (0 acts as 1,
// values above CAPACITY act as CAPACITY). Write only while idle.
// Timing: in the accept cycle every slot registers its key compare; in the
// update state, once the output register is free, the chain shifts by one
// step and the result is loaded into the output register. A new request is
// taken only after the update of the previous one, set by the
// compare-then-update loop through the slot chain. m_tvalid rises from the
// output register when that update loads it.
// Stall: a pending result does not block the next request from being taken;
// the update of that next request waits until the output register is free.
// Reset (synchronous, aresetn low) empties the cache, clears the output
// register's valid flag and restores capacity_in_use to 16.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int CAPACITY = LKVC_CAPACITY
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic [0:0]       s_tuser,   // [0] mode
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]       m_tuser    // [0] hit, [1] evicted
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int LW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic state_reg, state_next;
    logic [CFG_W-1:0] cap_reg, cap_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    // latched request
    logic             mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             m_hit_reg, m_hit_next;
    logic             m_ev_reg, m_ev_next;
    logic [VAL_W-1:0] m_rd_reg, m_rd_next;
    logic [KEY_W-1:0] m_evk_reg, m_evk_next;

    logic s_acc, go;
    logic hit, ev, is_put;
    logic [OCC_W-1:0] found, shift_n, lim;
    logic [LW-1:0]    cfg_l;
    logic [VAL_W-1:0] hit_value;
    logic [KEY_W-1:0] last_key;

    lkvc_ent_t  ents [CAPACITY];
    lkvc_ctrl_t ctrl [CAPACITY];
    logic [CAPACITY-1:0] match;
    lkvc_ent_t  new_ent;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign go       = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);
    assign is_put   = (mode_reg == MODE_PUT);

    // effective capacity: clamp to [1, CAPACITY]
    always_comb begin
        cfg_l = LW'(cap_reg);
        if (cfg_l == '0)
            lim = OCC_W'(1);
        else if (cfg_l > CAP_L)
            lim = OCC_W'(CAPACITY);
        else
            lim = OCC_W'(cfg_l);
    end

    // reduce slot compares; at most one slot matches since keys are unique
    always_comb begin
        hit       = 1'b0;
        found     = '0;
        hit_value = '0;
        last_key  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit       = hit | match[i];
            found     = found | (match[i] ? OCC_W'(i) : '0);
            hit_value = hit_value | (match[i] ? ents[i].value : '0);
            last_key  = last_key | ((OCC_W'(i + 1) == occ_reg) ? ents[i].key : '0);
        end
    end

    always_comb begin
        ev = is_put && !hit && (occ_reg >= lim) && (occ_reg != '0);
        if (hit)
            shift_n = found;
        else if (ev)
            shift_n = occ_reg - OCC_W'(1);
        else
            shift_n = occ_reg;
        new_ent.valid = 1'b1;
        new_ent.key   = key_reg;
        new_ent.value = (hit && !is_put) ? hit_value : val_reg;
    end

    // per-slot control: compare at accept, shift on update
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i].cmp_en = s_acc;
            ctrl[i].load   = go && (hit || is_put) && (OCC_W'(i) <= shift_n);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            lkvc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl[g]),
                .cmp_key  (s_tdata[KEY_W-1:0]),
                .prev_ent (new_ent),
                .ent      (ents[g]),
                .match    (match[g])
            );
        end else begin : g_body
            lkvc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl[g]),
                .cmp_key  (s_tdata[KEY_W-1:0]),
                .prev_ent (ents[g-1]),
                .ent      (ents[g]),
                .match    (match[g])
            );
        end
    end

    always_comb begin
        state_next   = state_reg;
        cap_next     = cfg_we ? cfg_wdata : cap_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_hit_next   = m_hit_reg;
        m_ev_next    = m_ev_reg;
        m_rd_next    = m_rd_reg;
        m_evk_next   = m_evk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc)
                    state_next = ST_UPD;
            end
            ST_UPD: begin
                if (go) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_hit_next   = hit;
                    m_ev_next    = ev;
                    m_rd_next    = (hit && !is_put) ? hit_value : '0;
                    m_evk_next   = ev ? last_key : '0;
                    // eviction keeps occupancy; a plain insert grows it
                    if (is_put && !hit && !ev)
                        occ_next = occ_reg + OCC_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CFG_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            mode_reg <= s_tuser[0];
            key_reg  <= s_tdata[KEY_W-1:0];
            val_reg  <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        m_hit_reg <= m_hit_next;
        m_ev_reg  <= m_ev_next;
        m_rd_reg  <= m_rd_next;
        m_evk_reg <= m_evk_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_evk_reg, m_rd_reg};
    assign m_tuser  = {m_ev_reg, m_hit_reg};

endmodule

/* rtl/lkvc_checker.sv */
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `LKVC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `LKVC_ASSERT_NOW(a_evict_is_miss, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0], "eviction reported on a hit")

    `LKVC_ASSERT_NOW(a_miss_value_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0, "read value nonzero without a hit")

    `LKVC_ASSERT_NOW(a_evk_zero, aclk, aresetn, m_tvalid && !m_tuser[1], m_tdata[63:32] == 32'd0, "evicted key nonzero without eviction")

    `LKVC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while update pending")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/sv/lru_cache_checker.sv */
// Checker for the LRU key-value cache: mirrors cache state and compares every result.
`timescale 1ns / 100ps

module lru_cache_checker
    import lkvc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [63:0]      s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic [0:0]       s_tuser,   // [0] mode
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [63:0]      m_tdata,   // [31:0] read_value, [63:32] evicted_key
    input  logic [1:0]       m_tuser,   // [0] hit, [1] evicted
    output int               fail_count,
    output int               outstanding,
    output int               hit_total,
    output int               evict_total
);

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_result_t;

    // mirror of the slot chain; slot 0 is most recent
    logic [KEY_W-1:0] slot_key   [LKVC_CAPACITY];
    logic [VAL_W-1:0] slot_value [LKVC_CAPACITY];
    logic             slot_valid [LKVC_CAPACITY];
    int               fill_level;
    logic [CFG_W-1:0] capacity_reg;

    cache_result_t pending_results[$];
    int mismatches, hits_seen, evicts_seen;

    assign fail_count  = mismatches;
    assign hit_total   = hits_seen;
    assign evict_total = evicts_seen;

    initial begin
        mismatches  = 0;
        hits_seen   = 0;
        evicts_seen = 0;
        outstanding = 0;
    end

    // shift slots 0..n-1 down one and place the entry at the front
    function automatic void move_to_front(input int n, input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
        for (int i = n; i > 0; i--) begin
            slot_key[i]   = slot_key[i-1];
            slot_value[i] = slot_value[i-1];
            slot_valid[i] = slot_valid[i-1];
        end
        slot_key[0]   = k;
        slot_value[0] = v;
        slot_valid[0] = 1'b1;
    endfunction

    function automatic cache_result_t predict_access(input logic md,
                                                     input logic [KEY_W-1:0] k,
                                                     input logic [VAL_W-1:0] v);
        cache_result_t r;
        int found, lim, last;
        logic [VAL_W-1:0] held;
        r = '0;
        found = -1;
        for (int i = 0; i < fill_level; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == k)
                found = i;

        if (found >= 0) begin
            r.hit = 1'b1;
            held  = slot_value[found];
            if (md == MODE_PUT)
                held = v;
            else
                r.read_value = held;
            move_to_front(found, k, held);
        end else if (md == MODE_PUT) begin
            // zero acts as one, anything above the array size saturates
            lim = int'(capacity_reg);
            if (lim < 1) lim = 1;
            if (lim > LKVC_CAPACITY) lim = LKVC_CAPACITY;
            if (fill_level >= lim && fill_level > 0) begin
                last = fill_level - 1;
                r.evicted     = 1'b1;
                r.evicted_key = slot_key[last];
                slot_key[last]   = '0;
                slot_value[last] = '0;
                slot_valid[last] = 1'b0;
                fill_level       = last;
            end
            if (fill_level < LKVC_CAPACITY) begin
                move_to_front(fill_level, k, v);
                fill_level++;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        cache_result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < LKVC_CAPACITY; i++) begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_valid[i] = 1'b0;
            end
            fill_level   = 0;
            capacity_reg = CFG_RESET;
            pending_results.delete();
        end else begin
            if (cfg_we)
                capacity_reg = cfg_wdata;

            // results first so a same-cycle request cannot pair with them
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[31:0], m_tuser[1], m_tdata[63:32]};
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                        mismatches++;
                    end
                    if (got.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h, got %h",
                               want.evicted_key, got.evicted_key);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                want = predict_access(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
                if (want.hit) hits_seen++;
                if (want.evicted) evicts_seen++;
                pending_results.push_back(want);
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the LRU key-value cache: reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import lkvc_pkg::*;

    localparam int POOL_MAX    = 20;
    localparam int PHASE_ITEMS = 80;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;   // [31:0] lookup_key, [63:32] write_value
    logic [0:0]       s_tuser   = '0;   // [0] mode
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [63:0]      m_tdata;          // [31:0] read_value, [63:32] evicted_key
    logic [1:0]       m_tuser;          // [0] hit, [1] evicted

    int fail_count, outstanding, hit_total, evict_total;

    // idle / stall percentages, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int requests_sent = 0;
    int cap_writes    = 0;

    // keys reused within a phase so gets hit and puts update or evict
    logic [KEY_W-1:0] key_pool [POOL_MAX];

    int phase_caps [8] = '{1, 2, 3, 5, 8, 16, 0, 31};

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    lru_key_value_cache_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lru_cache_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .hit_total   (hit_total),
        .evict_total (evict_total)
    );

    // Result side back-pressure: redrawn every cycle from the phase's stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drive one request; idle cycles before it at the phase's rate, then hold
    // it until the cache accepts it.
    task automatic send_request(input logic md, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {v, k};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Stop sending and wait until every result is back. The checker's count
    // is registered, hence the first edge before looking at it.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        // spare idle cycles keep the chain quiet
        repeat (4) @(posedge aclk);
    endtask

    // capacity_in_use may only change with the cache idle
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    // Random phase: mostly keys from a pool a little larger than the active
    // limit, so hits, updates and evictions all show up; some fully random keys.
    task automatic run_random_phase(input int n_items, input int cap);
        logic [KEY_W-1:0] k;
        int lim, pool_n;
        lim = (cap < 1) ? 1 : (cap > LKVC_CAPACITY) ? LKVC_CAPACITY : cap;
        pool_n = lim + 3;
        // keep about half the old pool so earlier entries still get hit
        for (int i = 0; i < POOL_MAX; i++)
            if ($urandom_range(1)) key_pool[i] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 15)
                k = $urandom;
            else
                k = key_pool[$urandom_range(pool_n - 1)];
            send_request($urandom_range(1) ? MODE_PUT : MODE_GET, k, $urandom);
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;

        // hold synchronous reset, then release it
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part, capacity at its reset value of 16 ---
        // empty cache: key 0 must miss even if a slot's stored key happens to be zero
        send_request(MODE_GET, 32'h0000_0000, 32'hDEAD_BEEF);
        send_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);   // hit, oldest entry
        send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h1234_5678);   // hit, value updated
        send_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);   // new value back
        send_request(MODE_GET, 32'h0000_0005, 32'h0000_0000);   // miss, no change

        // limit lowered below occupancy: each new key evicts exactly one
        write_capacity(5'd2);
        send_request(MODE_PUT, 32'h0000_0001, 32'hAAAA_5555);
        send_request(MODE_PUT, 32'h0000_0002, 32'h5555_AAAA);
        send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);   // already evicted

        // zero behaves as a limit of one
        write_capacity(5'd0);
        send_request(MODE_PUT, 32'h0000_0003, 32'h0F0F_0F0F);
        send_request(MODE_GET, 32'h0000_0003, 32'h0000_0000);

        // above the array size: saturates at 16
        write_capacity(5'd31);
        send_request(MODE_PUT, 32'hCAFE_0000, 32'hF0F0_F0F0);
        send_request(MODE_GET, 32'hCAFE_0000, 32'h0000_0000);

        // --- random part: one phase per capacity setting, cycling idle modes ---
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p][CFG_W-1:0]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            run_random_phase(PHASE_ITEMS, phase_caps[p]);
        end

        drain_results();
        repeat (10) @(posedge aclk);

        $display("Sent %0d requests over %0d capacity settings: %0d hits, %0d evictions.",
                 requests_sent, cap_writes + 1, hit_total, evict_total);
        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
